### rtl/hdt_pkg.sv
`default_nettype none

package hdt_pkg;

    // Transaction kinds carried in the low bits of s_axis_tuser.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TICK  = 2'd0;
    localparam kind_t KIND_READ  = 2'd1;
    localparam kind_t KIND_WRITE = 2'd2;

    // Register selector codes.
    typedef logic [1:0] reg_sel_t;
    localparam reg_sel_t REG_DIV  = 2'd0;
    localparam reg_sel_t REG_TIMA = 2'd1;
    localparam reg_sel_t REG_TMA  = 2'd2;
    localparam reg_sel_t REG_TAC  = 2'd3;

    localparam int unsigned TAC_ENABLE_BIT = 2;
    localparam int unsigned REM_W = 11;
    localparam int unsigned ACC_W = 12;

    typedef logic [REM_W-1:0] period_t;

    // Counter period in machine cycles for each rate select code.
    function automatic period_t rate_period(input logic [1:0] rate);
        period_t p;
        unique case (rate)
            2'd0: p = period_t'(1024);
            2'd1: p = period_t'(16);
            2'd2: p = period_t'(64);
            2'd3: p = period_t'(256);
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/handheld_console_divider_timer.sv
`default_nettype none

// Result timing: a read, write, undefined or counter-disabled tick transaction gives its result in
// the cycle after acceptance; an enabled tick first runs the counter loop, one step per elapsed
// period, and gives its result once the loop ends and the result register is free.
// Throughput: one transaction at a time; the counter loop retires one counter step per cycle
// through a single 12-bit subtract-and-compare unit, which sets the tick duration.
// Reset: aresetn (synchronous, active low) clears all timer registers and the result valid flag.
module handheld_console_divider_timer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] write_data, [15:8] tick_cycles
    input  wire logic [3:0]  s_axis_tuser,   // [1:0] kind, [3:2] reg_select
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] read_data
    output logic             m_axis_tuser    // [0] timer_irq
);
    import hdt_pkg::*;

    // Sequencer states.
    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    // Unpack the incoming transaction.
    kind_t      in_kind;
    reg_sel_t   in_sel;
    logic [7:0] in_wdata;
    logic [7:0] in_cycles;
    assign in_kind   = s_axis_tuser[1:0];
    assign in_sel    = s_axis_tuser[3:2];
    assign in_wdata  = s_axis_tdata[7:0];
    assign in_cycles = s_axis_tdata[15:8];

    // Architectural timer state.
    logic [7:0]       div_reg,     div_next;
    logic [7:0]       div_rem_reg, div_rem_next;
    logic [7:0]       tima_reg,    tima_next;
    logic [REM_W-1:0] cnt_rem_reg, cnt_rem_next;
    logic [7:0]       tma_reg,     tma_next;
    logic [7:0]       tac_reg,     tac_next;

    // Sequencer working state.
    logic [0:0]       state_reg,  state_next;
    logic [ACC_W-1:0] acc_reg,    acc_next;
    period_t          period_reg, period_next;
    logic             irq_reg,    irq_next;

    // Result register, which decouples the result channel from the sequencer.
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg,  out_data_next;
    logic             out_irq_reg,   out_irq_next;

    logic             in_fire;
    logic             out_free;
    logic [8:0]       div_sum;
    logic [ACC_W-1:0] period_ext;
    logic             step_ok;

    // The result register can take a new value when it is empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign div_sum    = {1'b0, div_rem_reg} + {1'b0, in_cycles};
    assign period_ext = ACC_W'(period_reg);
    // The shared unit: one compare of the accumulated cycles against the period.
    assign step_ok    = acc_reg >= period_ext;

    always_comb begin
        div_next       = div_reg;
        div_rem_next   = div_rem_reg;
        tima_next      = tima_reg;
        cnt_rem_next   = cnt_rem_reg;
        tma_next       = tma_reg;
        tac_next       = tac_reg;
        state_next     = state_reg;
        acc_next       = acc_reg;
        period_next    = period_reg;
        irq_next       = irq_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_irq_next   = out_irq_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_kind)
                        KIND_TICK: begin
                            // The divider can rise at most once per tick, so it is settled at once.
                            div_next     = div_reg + 8'(div_sum[8]);
                            div_rem_next = div_sum[7:0];
                            acc_next     = ACC_W'(cnt_rem_reg) + ACC_W'(in_cycles);
                            period_next  = rate_period(tac_reg[1:0]);
                            irq_next     = 1'b0;
                            if (tac_reg[TAC_ENABLE_BIT]) begin
                                state_next = ST_RUN;
                            end else begin
                                // A disabled counter leaves its remainder untouched.
                                out_valid_next = 1'b1;
                                out_data_next  = 8'h00;
                                out_irq_next   = 1'b0;
                            end
                        end
                        KIND_READ: begin
                            out_valid_next = 1'b1;
                            out_irq_next   = 1'b0;
                            unique case (in_sel)
                                REG_DIV:  out_data_next = div_reg;
                                REG_TIMA: out_data_next = tima_reg;
                                REG_TMA:  out_data_next = tma_reg;
                                REG_TAC:  out_data_next = tac_reg;
                            endcase
                        end
                        KIND_WRITE: begin
                            out_valid_next = 1'b1;
                            out_data_next  = 8'h00;
                            out_irq_next   = 1'b0;
                            unique case (in_sel)
                                REG_DIV:  div_next  = 8'h00;
                                REG_TIMA: tima_next = in_wdata;
                                REG_TMA:  tma_next  = in_wdata;
                                REG_TAC:  tac_next  = in_wdata;
                            endcase
                        end
                        default: begin
                            // An undefined kind changes nothing and returns zeros.
                            out_valid_next = 1'b1;
                            out_data_next  = 8'h00;
                            out_irq_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (step_ok) begin
                    acc_next = acc_reg - period_ext;
                    if (tima_reg == 8'hFF) begin
                        tima_next = tma_reg;
                        irq_next  = 1'b1;
                    end else begin
                        tima_next = tima_reg + 8'd1;
                    end
                end else if (out_free) begin
                    cnt_rem_next   = acc_reg[REM_W-1:0];
                    out_valid_next = 1'b1;
                    out_data_next  = 8'h00;
                    out_irq_next   = irq_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_reg       <= '0;
            div_rem_reg   <= '0;
            tima_reg      <= '0;
            cnt_rem_reg   <= '0;
            tma_reg       <= '0;
            tac_reg       <= '0;
            irq_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_reg       <= div_next;
            div_rem_reg   <= div_rem_next;
            tima_reg      <= tima_next;
            cnt_rem_reg   <= cnt_rem_next;
            tma_reg       <= tma_next;
            tac_reg       <= tac_next;
            irq_reg       <= irq_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        period_reg   <= period_next;
        out_data_reg <= out_data_next;
        out_irq_reg  <= out_irq_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_irq_reg;

`ifndef SYNTHESIS
    // A read, write or undefined transaction produces its result in the next cycle.
    a_direct_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_kind != KIND_TICK) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("non-tick transaction did not produce a result");

    // An enabled tick always enters the counter loop.
    a_tick_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_kind == KIND_TICK && tac_reg[TAC_ENABLE_BIT]) |=> state_reg == ST_RUN)
        else $error("enabled tick skipped the counter loop");

    // Each loop iteration consumes exactly one period.
    a_step_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_ok) |=> acc_reg == $past(acc_reg) - $past(period_ext))
        else $error("counter loop did not consume one period");

    // An interrupt result never carries read data.
    a_irq_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_irq_reg) |-> out_data_reg == 8'h00)
        else $error("interrupt result carries read data");
`endif

endmodule

`default_nettype wire
